[hw/rtl/qhp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the QUIC header parser.
// Used by qhp_parse, qhp_rsp_queue and quic_header_parser_unit; no dependencies.
package qhp_pkg;

   // Default limit on connection ID length
   localparam int unsigned MAX_CID_LEN_DEF = 20;

   // Result queue depth and derived widths
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] FORM_LONG_MASK = 8'h80;
   localparam logic [5:0] COUNT_SAT      = 6'h3F;
   localparam logic [5:0] LONG_FIXED_LEN = 6'd5;

   typedef enum logic [1:0] {
      KIND_DEST_ID = 2'd0,
      KIND_SRC_ID  = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_VERSION = 3'd1,
      PH_DLEN    = 3'd2,
      PH_DID     = 3'd3,
      PH_SLEN    = 3'd4,
      PH_SID     = 3'd5,
      PH_SKIP    = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  id_byte;
      logic        form;
      logic [1:0]  pkt_type;
      logic [31:0] version;
      logic [4:0]  dest_id_len;
      logic [4:0]  src_id_len;
      logic [5:0]  header_len;
      logic        run_last;
   } result_type;

   // Up to two results produced by one byte, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } batch_type;

endpackage

[hw/rtl/qhp_parse.sv]
`timescale 1ns / 1ps
// Input register, header state and per-byte parse logic of the QUIC header parser.
// Uses qhp_pkg; feeds qhp_rsp_queue with up to two results per byte.
module qhp_parse #(
   parameter int unsigned MAX_CID_LEN = qhp_pkg::MAX_CID_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                csr_valid,
   input  logic [4:0]          csr_data,
   input  logic                room,
   output qhp_pkg::batch_type  batch
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eod_ff;

   // Header state
   qhp_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  byte_count_ff, byte_count_in;
   logic [31:0] version_ff, version_in;
   logic [1:0]  type_ff, type_in;
   logic        form_ff, form_in;
   logic [4:0]  dest_len_ff, dest_len_in;
   logic [4:0]  src_len_ff, src_len_in;
   logic [4:0]  id_rem_ff, id_rem_in;
   logic [4:0]  local_cid_len_ff;

   logic       fire;
   logic       id_emit;
   logic       id_src;
   logic       done_hit;
   logic       len_err;
   logic       trunc_err;
   logic       finished;
   logic [5:0] count_inc;
   qhp_pkg::result_type id_res;
   qhp_pkg::result_type tail_res;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign count_inc  = (byte_count_ff == qhp_pkg::COUNT_SAT) ? byte_count_ff
                                                             : byte_count_ff + 6'd1;

   // Hold the byte until the queue has room for its results
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eod_ff  <= req_tlast;
      end
   end

   // Next state of the header parse
   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      version_in    = version_ff;
      type_in       = type_ff;
      form_in       = form_ff;
      dest_len_in   = dest_len_ff;
      src_len_in    = src_len_ff;
      id_rem_in     = id_rem_ff;
      id_emit       = 1'b0;
      id_src        = 1'b0;
      done_hit      = 1'b0;
      len_err       = 1'b0;
      trunc_err     = 1'b0;
      finished      = 1'b0;
      case (phase_ff)
         qhp_pkg::PH_FIRST: begin
            byte_count_in = 6'd1;
            version_in    = '0;
            type_in       = '0;
            src_len_in    = '0;
            dest_len_in   = '0;
            id_rem_in     = '0;
            if ((in_byte_ff & qhp_pkg::FORM_LONG_MASK) != 8'h00) begin
               form_in  = 1'b1;
               type_in  = in_byte_ff[5:4];
               phase_in = qhp_pkg::PH_VERSION;
            end else begin
               form_in = 1'b0;
               if (local_cid_len_ff > 5'(MAX_CID_LEN)) begin
                  len_err  = 1'b1;
                  finished = 1'b1;
               end else begin
                  dest_len_in = local_cid_len_ff;
                  if (local_cid_len_ff == 5'd0) begin
                     done_hit = 1'b1;
                     finished = 1'b1;
                  end else begin
                     id_rem_in = local_cid_len_ff;
                     phase_in  = qhp_pkg::PH_DID;
                  end
               end
            end
         end
         qhp_pkg::PH_VERSION: begin
            byte_count_in = count_inc;
            version_in    = {version_ff[23:0], in_byte_ff};
            if (count_inc >= qhp_pkg::LONG_FIXED_LEN) begin
               phase_in = qhp_pkg::PH_DLEN;
            end
         end
         qhp_pkg::PH_DLEN: begin
            byte_count_in = count_inc;
            if (in_byte_ff > 8'(MAX_CID_LEN)) begin
               len_err  = 1'b1;
               finished = 1'b1;
            end else begin
               dest_len_in = in_byte_ff[4:0];
               if (in_byte_ff == 8'd0) begin
                  phase_in = qhp_pkg::PH_SLEN;
               end else begin
                  id_rem_in = in_byte_ff[4:0];
                  phase_in  = qhp_pkg::PH_DID;
               end
            end
         end
         qhp_pkg::PH_DID: begin
            byte_count_in = count_inc;
            id_emit       = 1'b1;
            id_rem_in     = id_rem_ff - 5'd1;
            if (id_rem_in == 5'd0) begin
               if (form_ff) begin
                  phase_in = qhp_pkg::PH_SLEN;
               end else begin
                  done_hit = 1'b1;
                  finished = 1'b1;
               end
            end
         end
         qhp_pkg::PH_SLEN: begin
            byte_count_in = count_inc;
            if (in_byte_ff > 8'(MAX_CID_LEN)) begin
               len_err  = 1'b1;
               finished = 1'b1;
            end else begin
               src_len_in = in_byte_ff[4:0];
               if (in_byte_ff == 8'd0) begin
                  done_hit = 1'b1;
                  finished = 1'b1;
               end else begin
                  id_rem_in = in_byte_ff[4:0];
                  phase_in  = qhp_pkg::PH_SID;
               end
            end
         end
         qhp_pkg::PH_SID: begin
            byte_count_in = count_inc;
            id_emit       = 1'b1;
            id_src        = 1'b1;
            id_rem_in     = id_rem_ff - 5'd1;
            if (id_rem_in == 5'd0) begin
               done_hit = 1'b1;
               finished = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (finished) begin
         phase_in = qhp_pkg::PH_SKIP;
      end
      // End of datagram: flag an incomplete header, restart on the next byte
      if (in_eod_ff) begin
         if (phase_in != qhp_pkg::PH_SKIP) begin
            trunc_err = 1'b1;
         end
         phase_in = qhp_pkg::PH_FIRST;
      end
   end

   // Build the results of this byte from the updated state
   always_comb begin
      id_res          = '0;
      id_res.kind     = id_src ? qhp_pkg::KIND_SRC_ID : qhp_pkg::KIND_DEST_ID;
      id_res.id_byte  = in_byte_ff;

      tail_res = '0;
      if (done_hit) begin
         tail_res.kind        = qhp_pkg::KIND_DONE;
         tail_res.form        = form_in;
         tail_res.pkt_type    = type_in;
         tail_res.version     = version_in;
         tail_res.dest_id_len = dest_len_in;
         tail_res.src_id_len  = src_len_in;
         tail_res.header_len  = byte_count_in;
      end else begin
         tail_res.kind = qhp_pkg::KIND_ERROR;
      end
      tail_res.run_last = 1'b1;

      batch = '0;
      if (fire) begin
         if (id_emit) begin
            batch.first = id_res;
            if (done_hit || len_err || trunc_err) begin
               batch.second = tail_res;
               batch.count  = 2'd2;
            end else begin
               batch.first.run_last = 1'b1;
               batch.count          = 2'd1;
            end
         end else if (done_hit || len_err || trunc_err) begin
            batch.first = tail_res;
            batch.count = 2'd1;
         end
      end
   end

   // Advance header state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= qhp_pkg::PH_FIRST;
         byte_count_ff <= '0;
         version_ff    <= '0;
         type_ff       <= '0;
         form_ff       <= 1'b0;
         dest_len_ff   <= '0;
         src_len_ff    <= '0;
         id_rem_ff     <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         version_ff    <= version_in;
         type_ff       <= type_in;
         form_ff       <= form_in;
         dest_len_ff   <= dest_len_in;
         src_len_ff    <= src_len_in;
         id_rem_ff     <= id_rem_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         local_cid_len_ff <= '0;
      end else if (csr_valid) begin
         local_cid_len_ff <= csr_data;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      batch.count == 2'd2 |-> batch.second.run_last && !batch.first.run_last)
      else $error("two-result item has run_last on the wrong result");

   a_eod_restart: assert property (@(posedge clock) disable iff (reset)
      fire && in_eod_ff |=> phase_ff == qhp_pkg::PH_FIRST)
      else $error("end of datagram did not restart the parse");

   a_err_skip: assert property (@(posedge clock) disable iff (reset)
      fire && len_err && !in_eod_ff |=> phase_ff == qhp_pkg::PH_SKIP)
      else $error("length error did not drop the rest of the datagram");

endmodule

[hw/rtl/qhp_rsp_queue.sv]
`timescale 1ns / 1ps
// Result queue of the QUIC header parser: takes up to two results per cycle, gives one.
// Uses qhp_pkg; fed by qhp_parse.
module qhp_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  qhp_pkg::batch_type  batch,
   output logic                room,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output qhp_pkg::result_type rsp_item
);

   localparam int unsigned DEPTH = qhp_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = qhp_pkg::QPTR_W;
   localparam int unsigned CW    = qhp_pkg::QCNT_W;

   qhp_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_item   = mem_ff[rd_ptr_ff];
   assign room       = count_ff <= CW'(DEPTH - 2);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(batch.count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(batch.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store new results in arrival order
   always_ff @(posedge clock) begin
      if (batch.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= batch.first;
      end
      if (batch.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PW'(1)] <= batch.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      batch.count != 2'd0 |-> $past(count_ff) <= CW'(DEPTH) && room)
      else $error("results pushed without room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && batch.count == 2'd0 |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not drain the queue");

endmodule

[hw/rtl/quic_header_parser_unit.sv]
`timescale 1ns / 1ps
// QUIC packet header parser: takes one datagram byte per cycle and reports the
// connection ID bytes, then a completion or error item for the header.
// Takes one byte per cycle. A byte is registered in the input register, parsed
// from there, and its results are written into a four-entry result queue that
// offers them in arrival order.
// A byte that gives two results (the last ID byte together with the completion
// or an error) is drained one result at a time on the result side;
// the input stalls only while the queue holds more than two results, so
// with rsp_tready held high the rate stays at one byte per cycle.
// Short headers use the destination ID length set through the csr port,
// sampled at the first byte of each datagram; write it only while idle.
module quic_header_parser_unit #(
   parameter int unsigned MAX_CID_LEN = qhp_pkg::MAX_CID_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Datagram bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_datagram
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] id_byte, [8] form, [10:9] pkt_type,
                                    // [42:11] version, [47:43] dest_id_len,
                                    // [52:48] src_id_len, [58:53] header_len
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // run_last
   // Short header destination ID length
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   qhp_pkg::batch_type  batch;
   qhp_pkg::result_type rsp_item;
   logic                room;

   assign csr_ready = 1'b1;

   qhp_parse #(
      .MAX_CID_LEN (MAX_CID_LEN)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .room       (room),
      .batch      (batch)
   );

   qhp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result item onto the stream
   assign rsp_tdata = {5'b0, rsp_item.header_len, rsp_item.src_id_len,
                       rsp_item.dest_id_len, rsp_item.version, rsp_item.pkt_type,
                       rsp_item.form, rsp_item.id_byte};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.run_last;

endmodule
